@@ rtl/dhcpc_pkg.sv @@
`default_nettype none

package dhcpc_pkg;

    localparam int LEASE_BITS_DEF = 28;
    localparam int CFG_W          = 28;
    localparam int CD_W           = 28;
    localparam int CFG_IDX_W      = 4;
    localparam int Q_DEPTH        = 4;
    localparam int LEASE_MIN      = 10;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_STOP   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_PACKET = 2'd3;

    localparam logic [7:0] MSG_NONE  = 8'd0;
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;
    localparam logic [7:0] MSG_NAK   = 8'd6;

    localparam logic [2:0] ST_INIT       = 3'd0;
    localparam logic [2:0] ST_REQUESTING = 3'd1;
    localparam logic [2:0] ST_BOUND      = 3'd2;
    localparam logic [2:0] ST_RENEWING   = 3'd3;
    localparam logic [2:0] ST_REBINDING  = 3'd4;
    localparam logic [2:0] ST_RELEASED   = 3'd5;

    localparam logic [2:0] K_NONE     = 3'd0;
    localparam logic [2:0] K_DISCOVER = 3'd1;
    localparam logic [2:0] K_REQUEST  = 3'd2;
    localparam logic [2:0] K_RENEW    = 3'd3;
    localparam logic [2:0] K_REBIND   = 3'd4;
    localparam logic [2:0] K_NAK      = 3'd5;

    localparam logic [2:0] A_DISCOVER = 3'd0;
    localparam logic [2:0] A_SELECT   = 3'd1;
    localparam logic [2:0] A_RENEW    = 3'd2;
    localparam logic [2:0] A_REBOUND  = 3'd3;
    localparam logic [2:0] A_RELEASE  = 3'd4;
    localparam logic [2:0] A_AVAIL    = 3'd5;
    localparam logic [2:0] A_NOLEASE  = 3'd6;
    localparam logic [2:0] A_LOST     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_DISC_LIMIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_LIMIT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_WAIT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_WAIT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK_WAIT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DFLT_LEASE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RENEW_FLOOR = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REBIND_FLOOR = 4'd7;

    localparam logic [7:0]       RST_DISC_LIMIT   = 8'd5;
    localparam logic [7:0]       RST_REQ_LIMIT    = 8'd5;
    localparam logic [7:0]       RST_DISC_WAIT    = 8'd3;
    localparam logic [7:0]       RST_REQ_WAIT     = 8'd3;
    localparam logic [7:0]       RST_NAK_WAIT     = 8'd3;
    localparam logic [CFG_W-1:0] RST_DFLT_LEASE   = 28'd3600;
    localparam logic [CFG_W-1:0] RST_RENEW_FLOOR  = 28'd60;
    localparam logic [CFG_W-1:0] RST_REBIND_FLOOR = 28'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  msg_type;
        logic        owner_match;
        logic [31:0] server_id;
        logic [31:0] your_ip;
        logic        lease_present;
        logic [31:0] lease_value;
    } dhcpc_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] addr_ip;
        logic [31:0] addr_server;
        logic [27:0] lease_secs;
        logic [2:0]  client_state;
        logic        last;
    } dhcpc_out_t;

endpackage

`default_nettype wire

@@ rtl/dhcp_client_lease_fsm.sv @@
`default_nettype none

// DHCP client lease controller. Each accepted event (start, stop, one-second
// tick or parsed packet) updates the client state in the cycle it is accepted
// and pushes zero, one or two result transactions into a four-entry output
// queue; an event that causes no result leaves nothing behind. One event per
// cycle is sustained while m_ready stays high and the queue holds two results
// or fewer; s_ready drops only while it holds more, since an event may push
// two at once. Results are queued on acceptance. Configuration writes
// take effect at the write edge and must be made while the block is idle.
module dhcp_client_lease_fsm #(
    parameter int LEASE_BITS = dhcpc_pkg::LEASE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dhcpc_pkg::dhcpc_in_t                s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dhcpc_pkg::dhcpc_out_t                    m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [dhcpc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [dhcpc_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int QD = dhcpc_pkg::Q_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);
    localparam int CDW = dhcpc_pkg::CD_W;

    logic [7:0]     disc_limit_reg, req_limit_reg, disc_wait_reg, req_wait_reg, nak_wait_reg;
    logic [dhcpc_pkg::CFG_W-1:0] dflt_lease_reg, renew_floor_reg, rebind_floor_reg;

    logic [2:0]            state_reg, state_next;
    logic [7:0]            rc_reg, rc_next;
    logic [7:0]            nrc_reg, nrc_next;
    logic [31:0]           srv_reg, srv_next;
    logic [31:0]           req_reg, req_next;
    logic [LEASE_BITS-1:0] lease_reg, lease_next;
    logic [CDW-1:0]        cd_reg, cd_next;
    logic [2:0]            kind_reg, kind_next;

    logic [LEASE_BITS-1:0] lease_half, ack_lease, lv_m, dflt_m;
    logic [31:0]           half32, half_arm32, ack_arm32, dflt32, lease_out32;
    logic [31:0]           renew_floor32, rebind_floor32;
    logic [CDW-1:0]        half_arm, ack_arm;

    logic       start_now, req_now, slot;
    logic [1:0] n_res;
    logic [2:0] res_act [2];
    logic [31:0] res_ip [2];
    logic [31:0] res_srv [2];

    dhcpc_pkg::dhcpc_out_t out0, out1;
    dhcpc_pkg::dhcpc_out_t q_reg [QD];
    logic [PW-1:0] wptr_reg, wptr_p1, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          accept, pop;
    logic [1:0]    n_acc;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;
    assign s_ready = cnt_reg <= CW'(QD - 2);
    assign m_valid = cnt_reg != '0;
    assign m_data  = q_reg[rptr_reg];

    assign lease_half     = lease_reg >> 1;
    assign half32         = 32'(lease_half);
    assign half_arm32     = 32'(lease_half >> 1);
    assign half_arm       = half_arm32[CDW-1:0];
    assign renew_floor32  = 32'(renew_floor_reg);
    assign rebind_floor32 = 32'(rebind_floor_reg);
    assign lv_m           = s_data.lease_value[LEASE_BITS-1:0];
    assign dflt32         = 32'(dflt_lease_reg);
    assign dflt_m         = dflt32[LEASE_BITS-1:0];
    assign ack_lease      = !s_data.lease_present ? dflt_m :
                            (lv_m < LEASE_BITS'(dhcpc_pkg::LEASE_MIN)) ?
                            LEASE_BITS'(dhcpc_pkg::LEASE_MIN) : lv_m;
    assign ack_arm32      = 32'(ack_lease >> 1);
    assign ack_arm        = ack_arm32[CDW-1:0];

    always_comb begin
        state_next = state_reg;
        rc_next    = rc_reg;
        nrc_next   = nrc_reg;
        srv_next   = srv_reg;
        req_next   = req_reg;
        lease_next = lease_reg;
        cd_next    = cd_reg;
        kind_next  = kind_reg;
        start_now  = 1'b0;
        req_now    = 1'b0;
        slot       = 1'b0;
        n_res      = 2'd0;
        for (int i = 0; i < 2; i++) begin
            res_act[i] = dhcpc_pkg::A_DISCOVER;
            res_ip[i]  = '0;
            res_srv[i] = '0;
        end

        case (s_data.req_type)
            dhcpc_pkg::REQ_START: begin
                start_now = 1'b1;
            end
            dhcpc_pkg::REQ_STOP: begin
                if (state_reg == dhcpc_pkg::ST_BOUND || state_reg == dhcpc_pkg::ST_RENEWING ||
                    state_reg == dhcpc_pkg::ST_REBINDING) begin
                    res_act[0] = dhcpc_pkg::A_RELEASE;
                    res_ip[0]  = req_reg;
                    res_srv[0] = srv_reg;
                    n_res      = 2'd1;
                end
                kind_next  = dhcpc_pkg::K_NONE;
                cd_next    = '0;
                rc_next    = '0;
                nrc_next   = '0;
                req_next   = '0;
                state_next = dhcpc_pkg::ST_RELEASED;
                lease_next = '0;
            end
            dhcpc_pkg::REQ_TICK: begin
                if (kind_reg != dhcpc_pkg::K_NONE) begin
                    if (cd_reg > CDW'(1)) begin
                        cd_next = cd_reg - CDW'(1);
                    end else begin
                        kind_next = dhcpc_pkg::K_NONE;
                        cd_next   = '0;
                        case (kind_reg)
                            dhcpc_pkg::K_DISCOVER: begin
                                rc_next   = sat_inc(rc_reg);
                                start_now = 1'b1;
                            end
                            dhcpc_pkg::K_REQUEST: begin
                                rc_next = sat_inc(rc_reg);
                                req_now = 1'b1;
                            end
                            dhcpc_pkg::K_RENEW: begin
                                lease_next = lease_half;
                                if (half32 <= renew_floor32) begin
                                    state_next = dhcpc_pkg::ST_REBINDING;
                                    kind_next  = dhcpc_pkg::K_REBIND;
                                end else begin
                                    state_next = dhcpc_pkg::ST_RENEWING;
                                    res_act[0] = dhcpc_pkg::A_RENEW;
                                    res_ip[0]  = req_reg;
                                    res_srv[0] = srv_reg;
                                    n_res      = 2'd1;
                                    kind_next  = dhcpc_pkg::K_RENEW;
                                end
                                cd_next = half_arm;
                            end
                            dhcpc_pkg::K_REBIND: begin
                                lease_next = lease_half;
                                res_ip[0]  = req_reg;
                                res_srv[0] = srv_reg;
                                n_res      = 2'd1;
                                if (half32 <= rebind_floor32) begin
                                    res_act[0] = dhcpc_pkg::A_LOST;
                                    rc_next    = '0;
                                    req_next   = '0;
                                    state_next = dhcpc_pkg::ST_INIT;
                                    start_now  = 1'b1;
                                    slot       = 1'b1;
                                end else begin
                                    res_act[0] = dhcpc_pkg::A_REBOUND;
                                    kind_next  = dhcpc_pkg::K_REBIND;
                                    cd_next    = half_arm;
                                end
                            end
                            dhcpc_pkg::K_NAK: begin
                                nrc_next   = sat_inc(nrc_reg);
                                rc_next    = nrc_next;
                                req_next   = '0;
                                state_next = dhcpc_pkg::ST_INIT;
                                start_now  = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                if (s_data.owner_match && s_data.msg_type != dhcpc_pkg::MSG_NONE) begin
                    if (state_reg == dhcpc_pkg::ST_INIT) begin
                        if (s_data.msg_type == dhcpc_pkg::MSG_OFFER) begin
                            kind_next  = dhcpc_pkg::K_NONE;
                            cd_next    = '0;
                            rc_next    = '0;
                            srv_next   = s_data.server_id;
                            req_next   = s_data.your_ip;
                            state_next = dhcpc_pkg::ST_REQUESTING;
                            req_now    = 1'b1;
                        end
                    end else if (state_reg == dhcpc_pkg::ST_REQUESTING ||
                                 state_reg == dhcpc_pkg::ST_RENEWING ||
                                 state_reg == dhcpc_pkg::ST_REBINDING) begin
                        if (s_data.msg_type == dhcpc_pkg::MSG_ACK) begin
                            rc_next    = '0;
                            lease_next = ack_lease;
                            res_act[0] = dhcpc_pkg::A_AVAIL;
                            res_ip[0]  = s_data.your_ip;
                            res_srv[0] = srv_reg;
                            n_res      = 2'd1;
                            state_next = dhcpc_pkg::ST_BOUND;
                            kind_next  = dhcpc_pkg::K_RENEW;
                            cd_next    = ack_arm;
                        end else if (s_data.msg_type == dhcpc_pkg::MSG_NAK) begin
                            rc_next   = '0;
                            kind_next = dhcpc_pkg::K_NAK;
                            cd_next   = CDW'(nak_wait_reg);
                        end
                    end
                end
            end
        endcase

        if (start_now) begin
            if (rc_next >= disc_limit_reg) begin
                res_act[slot] = dhcpc_pkg::A_NOLEASE;
                kind_next     = dhcpc_pkg::K_NONE;
                cd_next       = '0;
            end else begin
                if (rc_next == '0) begin
                    state_next = dhcpc_pkg::ST_INIT;
                end
                res_act[slot] = dhcpc_pkg::A_DISCOVER;
                kind_next     = dhcpc_pkg::K_DISCOVER;
                cd_next       = CDW'(disc_wait_reg);
            end
            res_ip[slot]  = '0;
            res_srv[slot] = '0;
            n_res         = slot ? 2'd2 : 2'd1;
        end

        if (req_now) begin
            if (rc_next >= req_limit_reg) begin
                state_next = dhcpc_pkg::ST_INIT;
                res_act[0] = dhcpc_pkg::A_NOLEASE;
                kind_next  = dhcpc_pkg::K_NONE;
                cd_next    = '0;
            end else begin
                if (rc_next == '0) begin
                    state_next = dhcpc_pkg::ST_REQUESTING;
                end
                res_act[0] = dhcpc_pkg::A_SELECT;
                res_ip[0]  = req_next;
                res_srv[0] = srv_next;
                kind_next  = dhcpc_pkg::K_REQUEST;
                cd_next    = CDW'(req_wait_reg);
            end
            n_res = 2'd1;
        end
    end

    assign lease_out32 = 32'(lease_next);

    always_comb begin
        out0.action       = res_act[0];
        out0.addr_ip      = res_ip[0];
        out0.addr_server  = res_srv[0];
        out0.lease_secs   = lease_out32[27:0];
        out0.client_state = state_next;
        out0.last         = n_res == 2'd1;
        out1.action       = res_act[1];
        out1.addr_ip      = res_ip[1];
        out1.addr_server  = res_srv[1];
        out1.lease_secs   = lease_out32[27:0];
        out1.client_state = state_next;
        out1.last         = 1'b1;
    end

    assign n_acc   = accept ? n_res : 2'd0;
    assign wptr_p1 = wptr_reg + PW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disc_limit_reg   <= dhcpc_pkg::RST_DISC_LIMIT;
            req_limit_reg    <= dhcpc_pkg::RST_REQ_LIMIT;
            disc_wait_reg    <= dhcpc_pkg::RST_DISC_WAIT;
            req_wait_reg     <= dhcpc_pkg::RST_REQ_WAIT;
            nak_wait_reg     <= dhcpc_pkg::RST_NAK_WAIT;
            dflt_lease_reg   <= dhcpc_pkg::RST_DFLT_LEASE;
            renew_floor_reg  <= dhcpc_pkg::RST_RENEW_FLOOR;
            rebind_floor_reg <= dhcpc_pkg::RST_REBIND_FLOOR;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dhcpc_pkg::CFG_DISC_LIMIT:   disc_limit_reg   <= cfg_wdata[7:0];
                dhcpc_pkg::CFG_REQ_LIMIT:    req_limit_reg    <= cfg_wdata[7:0];
                dhcpc_pkg::CFG_DISC_WAIT:    disc_wait_reg    <= cfg_wdata[7:0];
                dhcpc_pkg::CFG_REQ_WAIT:     req_wait_reg     <= cfg_wdata[7:0];
                dhcpc_pkg::CFG_NAK_WAIT:     nak_wait_reg     <= cfg_wdata[7:0];
                dhcpc_pkg::CFG_DFLT_LEASE:   dflt_lease_reg   <= cfg_wdata;
                dhcpc_pkg::CFG_RENEW_FLOOR:  renew_floor_reg  <= cfg_wdata;
                dhcpc_pkg::CFG_REBIND_FLOOR: rebind_floor_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dhcpc_pkg::ST_INIT;
            rc_reg    <= '0;
            nrc_reg   <= '0;
            srv_reg   <= '0;
            req_reg   <= '0;
            lease_reg <= '0;
            cd_reg    <= '0;
            kind_reg  <= dhcpc_pkg::K_NONE;
        end else if (accept) begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            nrc_reg   <= nrc_next;
            srv_reg   <= srv_next;
            req_reg   <= req_next;
            lease_reg <= lease_next;
            cd_reg    <= cd_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_reg + PW'(n_acc);
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(n_acc) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (n_acc != 2'd0) begin
            q_reg[wptr_reg] <= out0;
        end
        if (n_acc == 2'd2) begin
            q_reg[wptr_p1] <= out1;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(QD))
        else $error("result queue overflow");

    a_room_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (cnt_reg + CW'(n_res)) <= CW'(QD))
        else $error("event accepted without room for its results");

    a_stop_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == dhcpc_pkg::REQ_STOP |=>
        state_reg == dhcpc_pkg::ST_RELEASED && kind_reg == dhcpc_pkg::K_NONE &&
        lease_reg == '0)
        else $error("stop did not release the lease");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == dhcpc_pkg::REQ_TICK && kind_reg == dhcpc_pkg::K_NONE
        |=> state_reg == $past(state_reg) && cnt_reg <= $past(cnt_reg))
        else $error("tick with no countdown changed state");

    a_two_results_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && n_res == 2'd2 |-> res_act[0] == dhcpc_pkg::A_LOST)
        else $error("two results from an event other than lease loss");

endmodule

`default_nettype wire

@@ test/dhcp_client_lease_fsm_test.sv @@
`default_nettype none

module dhcp_client_lease_fsm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dhcpc_pkg::*;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    dhcpc_in_t            s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    dhcpc_out_t           m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int tx_idle_pct = 17;
    int rx_idle_pct = 17;
    int mismatches = 0;

    logic [7:0]  lim_discover, lim_request, wait_discover, wait_request, wait_nak;
    logic [27:0] lease_default, floor_renew, floor_rebind;

    logic [2:0]  cl_state;
    logic [7:0]  retries, nak_retries;
    logic [31:0] srv_addr, req_addr;
    logic [27:0] lease_left_s, timer;
    logic [2:0]  timer_kind;

    dhcpc_out_t event_results[$];
    dhcpc_out_t due_results[$];

    dhcp_client_lease_fsm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void reset_client();
        lim_discover  = RST_DISC_LIMIT;
        lim_request   = RST_REQ_LIMIT;
        wait_discover = RST_DISC_WAIT;
        wait_request  = RST_REQ_WAIT;
        wait_nak      = RST_NAK_WAIT;
        lease_default = RST_DFLT_LEASE;
        floor_renew   = RST_RENEW_FLOOR;
        floor_rebind  = RST_REBIND_FLOOR;
        cl_state      = ST_INIT;
        retries       = '0;
        nak_retries   = '0;
        srv_addr      = '0;
        req_addr      = '0;
        lease_left_s  = '0;
        timer         = '0;
        timer_kind    = K_NONE;
    endfunction

    function automatic void note_result(input logic [2:0] act, input logic [31:0] ip,
                                        input logic [31:0] srv);
        dhcpc_out_t r;
        if (event_results.size() >= 2)
            return;
        r = '0;
        r.action      = act;
        r.addr_ip     = ip;
        r.addr_server = srv;
        event_results.push_back(r);
    endfunction

    function automatic void arm_timer(input logic [2:0] kind, input logic [27:0] ticks);
        timer_kind = kind;
        timer      = ticks;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic void begin_discovery();
        if (retries >= lim_discover) begin
            note_result(A_NOLEASE, '0, '0);
            arm_timer(K_NONE, '0);
            return;
        end
        if (retries == 0)
            cl_state = ST_INIT;
        note_result(A_DISCOVER, '0, '0);
        arm_timer(K_DISCOVER, {20'd0, wait_discover});
    endfunction

    function automatic void begin_request();
        if (retries >= lim_request) begin
            cl_state = ST_INIT;
            note_result(A_NOLEASE, '0, '0);
            arm_timer(K_NONE, '0);
            return;
        end
        if (retries == 0)
            cl_state = ST_REQUESTING;
        note_result(A_SELECT, req_addr, srv_addr);
        arm_timer(K_REQUEST, {20'd0, wait_request});
    endfunction

    function automatic void restart_client(input logic [7:0] start_retries);
        arm_timer(K_NONE, '0);
        retries  = start_retries;
        req_addr = '0;
        cl_state = ST_INIT;
        begin_discovery();
    endfunction

    function automatic void timer_expired();
        logic [2:0] kind;
        kind = timer_kind;
        arm_timer(K_NONE, '0);
        case (kind)
            K_DISCOVER: begin
                retries = bump(retries);
                begin_discovery();
            end
            K_REQUEST: begin
                retries = bump(retries);
                begin_request();
            end
            K_RENEW: begin
                cl_state     = ST_RENEWING;
                lease_left_s = lease_left_s >> 1;
                if (lease_left_s <= floor_renew) begin
                    cl_state = ST_REBINDING;
                    arm_timer(K_REBIND, lease_left_s >> 1);
                end else begin
                    note_result(A_RENEW, req_addr, srv_addr);
                    arm_timer(K_RENEW, lease_left_s >> 1);
                end
            end
            K_REBIND: begin
                lease_left_s = lease_left_s >> 1;
                if (lease_left_s <= floor_rebind) begin
                    note_result(A_LOST, req_addr, srv_addr);
                    restart_client('0);
                end else begin
                    note_result(A_REBOUND, req_addr, srv_addr);
                    arm_timer(K_REBIND, lease_left_s >> 1);
                end
            end
            K_NAK: begin
                nak_retries = bump(nak_retries);
                restart_client(nak_retries);
            end
            default: ;
        endcase
    endfunction

    function automatic void take_packet(input dhcpc_in_t ev);
        logic [27:0] lv;
        if (!ev.owner_match || ev.msg_type == MSG_NONE)
            return;
        if (cl_state == ST_INIT) begin
            if (ev.msg_type != MSG_OFFER)
                return;
            arm_timer(K_NONE, '0);
            retries  = '0;
            srv_addr = ev.server_id;
            req_addr = ev.your_ip;
            cl_state = ST_REQUESTING;
            begin_request();
        end else if (cl_state == ST_REQUESTING || cl_state == ST_RENEWING ||
                     cl_state == ST_REBINDING) begin
            if (ev.msg_type == MSG_ACK) begin
                retries = '0;
                arm_timer(K_NONE, '0);
                if (ev.lease_present) begin
                    lv = ev.lease_value[27:0];
                    if (lv < 28'(LEASE_MIN))
                        lv = 28'(LEASE_MIN);
                end else begin
                    lv = lease_default;
                end
                lease_left_s = lv;
                note_result(A_AVAIL, ev.your_ip, srv_addr);
                cl_state = ST_BOUND;
                arm_timer(K_RENEW, lease_left_s >> 1);
            end else if (ev.msg_type == MSG_NAK) begin
                retries = '0;
                arm_timer(K_NAK, {20'd0, wait_nak});
            end
        end
    endfunction

    function automatic void advance_client(input dhcpc_in_t ev);
        dhcpc_out_t r;
        event_results.delete();
        case (ev.req_type)
            REQ_START: begin_discovery();
            REQ_STOP: begin
                if (cl_state == ST_BOUND || cl_state == ST_RENEWING ||
                    cl_state == ST_REBINDING)
                    note_result(A_RELEASE, req_addr, srv_addr);
                arm_timer(K_NONE, '0);
                retries      = '0;
                nak_retries  = '0;
                req_addr     = '0;
                cl_state     = ST_RELEASED;
                lease_left_s = '0;
            end
            REQ_TICK: begin
                if (timer_kind != K_NONE) begin
                    if (timer > 1)
                        timer = timer - 28'd1;
                    else
                        timer_expired();
                end
            end
            default: take_packet(ev);
        endcase
        for (int k = 0; k < event_results.size(); k++) begin
            r              = event_results[k];
            r.lease_secs   = lease_left_s;
            r.client_state = cl_state;
            r.last         = (k == event_results.size() - 1);
            due_results.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(input dhcpc_out_t got);
        dhcpc_out_t want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0h", $time, got);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        compare_field("action", 32'(want.action), 32'(got.action));
        compare_field("addr_ip", want.addr_ip, got.addr_ip);
        compare_field("addr_server", want.addr_server, got.addr_server);
        compare_field("lease_secs", 32'(want.lease_secs), 32'(got.lease_secs));
        compare_field("client_state", 32'(want.client_state), 32'(got.client_state));
        compare_field("last", 32'(want.last), 32'(got.last));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                advance_client(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    task automatic send_event(input dhcpc_in_t ev);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        int n;
        n = 0;
        s_valid <= 1'b0;
        @(negedge aclk);
        while (due_results.size() > 0 && n < 5000) begin
            @(negedge aclk);
            n++;
        end
        if (due_results.size() > 0) begin
            $display("%0t: missing results expected %0d actual 0", $time,
                     due_results.size());
            mismatches++;
            due_results.delete();
        end
    endtask

    task automatic settle();
        drain_results();
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DISC_LIMIT:   lim_discover  = val[7:0];
            CFG_REQ_LIMIT:    lim_request   = val[7:0];
            CFG_DISC_WAIT:    wait_discover = val[7:0];
            CFG_REQ_WAIT:     wait_request  = val[7:0];
            CFG_NAK_WAIT:     wait_nak      = val[7:0];
            CFG_DFLT_LEASE:   lease_default = val;
            CFG_RENEW_FLOOR:  floor_renew   = val;
            CFG_REBIND_FLOOR: floor_rebind  = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] d_lim, input logic [7:0] r_lim,
                                  input logic [7:0] d_wait, input logic [7:0] r_wait,
                                  input logic [7:0] n_wait, input logic [27:0] dflt,
                                  input logic [27:0] rfloor, input logic [27:0] bfloor);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        write_reg(CFG_DISC_LIMIT, {junk[19:0], d_lim});
        write_reg(CFG_REQ_LIMIT, {junk[27:8], r_lim});
        write_reg(CFG_DISC_WAIT, {junk[31:12], d_wait});
        write_reg(CFG_REQ_WAIT, {~junk[19:0], r_wait});
        write_reg(CFG_NAK_WAIT, {~junk[31:12], n_wait});
        write_reg(CFG_DFLT_LEASE, dflt);
        write_reg(CFG_RENEW_FLOOR, rfloor);
        write_reg(CFG_REBIND_FLOOR, bfloor);
        write_reg(CFG_REBIND_FLOOR + 4'd1 + 4'($urandom_range(7, 0)), junk[27:0]);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic dhcpc_in_t make_event(input logic [1:0] req, input logic [7:0] msg,
                                             input logic owner, input logic [31:0] sid,
                                             input logic [31:0] yip, input logic lp,
                                             input logic [31:0] lv);
        dhcpc_in_t ev;
        ev.req_type      = req;
        ev.msg_type      = msg;
        ev.owner_match   = owner;
        ev.server_id     = sid;
        ev.your_ip       = yip;
        ev.lease_present = lp;
        ev.lease_value   = lv;
        return ev;
    endfunction

    function automatic dhcpc_in_t random_event();
        dhcpc_in_t ev;
        int pick;
        ev.req_type      = REQ_TICK;
        ev.msg_type      = 8'($urandom);
        ev.owner_match   = 1'($urandom);
        ev.server_id     = $urandom;
        ev.your_ip       = $urandom;
        ev.lease_present = ($urandom_range(3, 0) != 0);
        case ($urandom_range(9, 0))
            0: ev.lease_value = $urandom;
            1: ev.lease_value = $urandom_range(9, 0);
            default: ev.lease_value = $urandom_range(120, 10);
        endcase
        pick = $urandom_range(99, 0);
        if (pick < 6) begin
            ev.req_type = REQ_START;
        end else if (pick < 9) begin
            ev.req_type = REQ_STOP;
        end else if (pick < 55) begin
            ev.req_type = REQ_TICK;
        end else begin
            ev.req_type = REQ_PACKET;
            if ($urandom_range(99, 0) >= 15) begin
                ev.owner_match = 1'b1;
                if (cl_state == ST_INIT)
                    ev.msg_type = MSG_OFFER;
                else if (cl_state == ST_BOUND || cl_state == ST_RELEASED)
                    ev.msg_type = ($urandom_range(1, 0) != 0) ? MSG_OFFER : MSG_ACK;
                else
                    ev.msg_type = ($urandom_range(9, 0) < 7) ? MSG_ACK : MSG_NAK;
            end
        end
        return ev;
    endfunction

    task automatic send_ticks(input int n);
        repeat (n) send_event(make_event(REQ_TICK, MSG_NONE, 1'b0, '0, '0, 1'b0, '0));
    endtask

    task automatic run_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 || $urandom_range(69, 0) == 0)
                drain_results();
            send_event(random_event());
        end
    endtask

    task automatic test_directed_cases();
        send_ticks(1);
        send_event(make_event(REQ_STOP, MSG_NONE, 1'b0, '0, '0, 1'b0, '0));
        send_event(make_event(REQ_START, MSG_NONE, 1'b0, '0, '0, 1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_OFFER, 1'b0, 32'h0a000001, 32'h0a000064,
                              1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_NONE, 1'b1, 32'h0a000001, 32'h0a000064,
                              1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_NAK, 1'b1, 32'h0a000001, 32'h0a000064,
                              1'b0, '0));
        send_ticks(3);
        send_event(make_event(REQ_PACKET, MSG_OFFER, 1'b1, 32'hffffffff, 32'hffffffff,
                              1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_ACK, 1'b1, 32'h0, 32'hffffffff,
                              1'b1, 32'hffffffff));
        send_event(make_event(REQ_PACKET, MSG_OFFER, 1'b1, 32'h1, 32'h2, 1'b0, '0));
        send_event(make_event(REQ_STOP, MSG_NONE, 1'b0, '0, '0, 1'b0, '0));
        send_event(make_event(REQ_START, MSG_NONE, 1'b0, '0, '0, 1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_OFFER, 1'b1, 32'h0, 32'h0, 1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_NAK, 1'b1, '0, '0, 1'b0, '0));
        send_ticks(3);
        send_event(make_event(REQ_PACKET, MSG_OFFER, 1'b1, 32'hc0a80001, 32'hc0a80017,
                              1'b0, '0));
        send_event(make_event(REQ_PACKET, MSG_ACK, 1'b1, 32'hc0a80001, 32'hc0a80017,
                              1'b1, 32'd3));
        send_ticks(7);
    endtask

    task automatic test_default_settings();
        apply_settings(RST_DISC_LIMIT, RST_REQ_LIMIT, RST_DISC_WAIT, RST_REQ_WAIT,
                       RST_NAK_WAIT, RST_DFLT_LEASE, RST_RENEW_FLOOR, RST_REBIND_FLOOR);
        run_traffic(300);
    endtask

    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(8'd2, 8'd2, 8'd1, 8'd2, 8'd1, 28'd40, 28'd8, 28'd2);
        run_traffic(200);
        tx_idle_pct = 17;
        rx_idle_pct = 17;
    endtask

    task automatic test_min_settings();
        apply_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 28'd10, 28'd0, 28'd0);
        run_traffic(300);
    endtask

    task automatic test_max_settings();
        apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 28'h0fffffff,
                       28'h0fffffff, 28'h0fffffff);
        run_traffic(120);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            apply_settings(8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)),
                           8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)),
                           8'($urandom_range(4, 1)), 28'($urandom_range(200, 10)),
                           28'($urandom_range(80, 0)), 28'($urandom_range(20, 0)));
            run_traffic(150);
        end
    endtask

    initial begin
        reset_client();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_default_settings();
        test_back_to_back();
        test_min_settings();
        test_max_settings();
        test_random_settings();
        settle();
        repeat (4) @(negedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/dhcpc_pkg.sv
rtl/dhcp_client_lease_fsm.sv
test/dhcp_client_lease_fsm_test.sv
